FILE: rtl/lsq4_pkg.sv
`default_nettype none
package lsq4_pkg;

  localparam int NUM_SUMS = 14;
  localparam int COUNT_BITS_DEF = 16;
  localparam logic signed [15:0] X3_ONE = 16'sd256;
  localparam logic [31:0] PIVOT_FLOOR_RST = 32'd1;
  localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] HI65 = {1'b0, SAT_MAX};
  localparam logic signed [64:0] LO65 = -HI65;
  localparam logic [2:0] OPND_Y = 3'd4;
  localparam logic [2:0] LAST_COL = 3'd4;

  typedef logic [NUM_SUMS-1:0][63:0] sums_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FEW      = 2'd1,
    ST_SINGULAR = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_ACC,
    F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_LOAD_W,
    S_PIV,
    S_PIV_CHK,
    S_DIAG,
    S_NORM,
    S_NORM_W,
    S_ELIM_F,
    S_ELIM_M,
    S_ELIM_MW,
    S_BACK_INIT,
    S_BACK_M,
    S_BACK_MW,
    S_OUT
  } solve_state_e;

  // upper-triangle sum index for matrix entry (i,j)
  localparam logic [3:0] SUM_SEL [16] = '{
    4'd0, 4'd1, 4'd2, 4'd3,
    4'd1, 4'd4, 4'd5, 4'd6,
    4'd2, 4'd5, 4'd7, 4'd8,
    4'd3, 4'd6, 4'd8, 4'd9
  };

  // operand pair of each sum slot: 0..3 regressors, 4 target
  localparam logic [2:0] OPND_A [16] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2,
    3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd3, 3'd3, 3'd3
  };
  localparam logic [2:0] OPND_B [16] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd1, 3'd2, 3'd3, 3'd2,
    3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3
  };

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] from_mag(input logic [63:0] m, input logic neg);
    logic [63:0] c;
    c = (m > SAT_MAX) ? SAT_MAX : m;
    return neg ? (64'd0 - c) : c;
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s > HI65) return SAT_MAX;
    if (s < LO65) return LO65[63:0];
    return s[63:0];
  endfunction

  // Q32.32 to Q16.16, round half away from zero, saturate
  function automatic logic [31:0] to_q16(input logic [63:0] v);
    logic [63:0] r;
    r = (mag64(v) + 64'h8000) >> 16;
    if (v[63]) begin
      if (r > 64'h8000_0000) r = 64'h8000_0000;
      r = 64'd0 - r;
      return r[31:0];
    end
    return (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
  endfunction

  function automatic logic [4:0] w_index(input logic [1:0] r, input logic [2:0] c);
    return 5'({r, 2'b00}) + 5'(r) + 5'(c);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/lsq4_front.sv
`default_nettype none
module lsq4_front #(
  parameter int COUNT_BITS = lsq4_pkg::COUNT_BITS_DEF
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start,
  output logic                      busy,
  input  wire  signed [15:0]        surface_temp_i,
  input  wire  signed [15:0]        vegetation_index_i,
  input  wire  signed [15:0]        building_height_i,
  input  wire  signed [15:0]        air_temp_observed_i,
  input  wire                       last_sample_i,
  input  wire                       q_full_i,
  output logic                      push_o,
  output lsq4_pkg::sums_t           sums_o,
  output logic [COUNT_BITS:0]       count_o
);

  localparam int CW = COUNT_BITS + 1;

  lsq4_pkg::front_state_e st_q, st_d;
  logic [1:0]          phase_q;
  logic signed [15:0]  x0_q, x1_q, x2_q, y_q;
  logic                last_q;
  logic [63:0]         sums_q [lsq4_pkg::NUM_SUMS];
  logic [CW-1:0]       count_q;
  logic signed [31:0]  prod [4];
  logic                accept;

  assign accept = start && !busy;

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      lsq4_pkg::F_IDLE: if (accept) st_d = lsq4_pkg::F_ACC;
      lsq4_pkg::F_ACC: begin
        if (phase_q == 2'd3) st_d = last_q ? lsq4_pkg::F_PUSH : lsq4_pkg::F_IDLE;
      end
      lsq4_pkg::F_PUSH: if (!q_full_i) st_d = lsq4_pkg::F_IDLE;
      default: st_d = lsq4_pkg::F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy   = (st_q != lsq4_pkg::F_IDLE);
    push_o = (st_q == lsq4_pkg::F_PUSH) && !q_full_i;
  end

  // four lane multipliers, operands picked per slot
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      logic [3:0] slot;
      logic signed [15:0] a, b;
      slot = {phase_q, 2'(l)};
      case (lsq4_pkg::OPND_A[slot])
        3'd0:    a = x0_q;
        3'd1:    a = x1_q;
        3'd2:    a = x2_q;
        default: a = lsq4_pkg::X3_ONE;
      endcase
      case (lsq4_pkg::OPND_B[slot])
        3'd0:             b = x0_q;
        3'd1:             b = x1_q;
        3'd2:             b = x2_q;
        lsq4_pkg::OPND_Y: b = y_q;
        default:          b = lsq4_pkg::X3_ONE;
      endcase
      prod[l] = a * b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= lsq4_pkg::F_IDLE;
      phase_q <= 2'd0;
      count_q <= '0;
      for (int s = 0; s < lsq4_pkg::NUM_SUMS; s++) sums_q[s] <= 64'd0;
    end else begin
      st_q <= st_d;
      if (accept) begin
        phase_q <= 2'd0;
        if (count_q != {CW{1'b1}}) count_q <= count_q + CW'(1);
      end else if (st_q == lsq4_pkg::F_ACC) begin
        phase_q <= phase_q + 2'd1;
      end
      // each sum is updated in its own phase by its own lane
      if (st_q == lsq4_pkg::F_ACC) begin
        for (int s = 0; s < lsq4_pkg::NUM_SUMS; s++) begin
          if (phase_q == 2'(s >> 2))
            sums_q[s] <= sums_q[s] + 64'(prod[s % 4]);
        end
      end
      // hand-off clears the set
      if (push_o) begin
        count_q <= '0;
        for (int s = 0; s < lsq4_pkg::NUM_SUMS; s++) sums_q[s] <= 64'd0;
      end
    end
  end

  // sample registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x0_q   <= surface_temp_i;
      x1_q   <= vegetation_index_i;
      x2_q   <= building_height_i;
      y_q    <= air_temp_observed_i;
      last_q <= last_sample_i;
    end
  end

  always_comb begin
    for (int s = 0; s < lsq4_pkg::NUM_SUMS; s++) sums_o[s] = sums_q[s];
    count_o = count_q;
  end

endmodule
`default_nettype wire

FILE: rtl/lsq4_queue.sv
`default_nettype none
module lsq4_queue #(
  parameter int COUNT_BITS = lsq4_pkg::COUNT_BITS_DEF
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  lsq4_pkg::sums_t       sums_i,
  input  wire  [COUNT_BITS:0]   count_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  wire                   pop_i,
  output lsq4_pkg::sums_t       sums_o,
  output logic [COUNT_BITS:0]   count_o
);

  logic                  valid_q;
  lsq4_pkg::sums_t       sums_q;
  logic [COUNT_BITS:0]   count_q;

  // one-entry request slot between accumulator and solver
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      sums_q  <= sums_i;
      count_q <= count_i;
    end
  end

  assign full_o  = valid_q;
  assign valid_o = valid_q;
  assign sums_o  = sums_q;
  assign count_o = count_q;

endmodule
`default_nettype wire

FILE: rtl/lsq4_div.sv
`default_nettype none
module lsq4_div (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire  [63:0] hi_i,
  input  wire  [63:0] lo_i,
  input  wire  [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic        run_q, done_q;
  logic [5:0]  cnt_q;
  logic [63:0] rem_q, lo_q, den_q, quo_q;
  logic [63:0] shifted;
  logic        take;

  // restoring step, one quotient bit per cycle
  always_comb begin
    shifted = {rem_q[62:0], lo_q[63]};
    take    = rem_q[63] || (shifted >= den_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= 6'd0;
        if (hi_i >= den_i) begin
          done_q <= 1'b1;
        end else begin
          run_q <= 1'b1;
        end
      end else if (run_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= hi_i;
      lo_q  <= lo_i;
      den_q <= den_i;
      // quotient overflow saturates
      quo_q <= (hi_i >= den_i) ? {64{1'b1}} : 64'd0;
    end else if (run_q) begin
      rem_q <= take ? (shifted - den_q) : shifted;
      lo_q  <= {lo_q[62:0], 1'b0};
      quo_q <= {quo_q[62:0], take};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

FILE: rtl/lsq4_mul.sv
`default_nettype none
module lsq4_mul (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire  [63:0] a_i,
  input  wire  [63:0] b_i,
  output logic        done_o,
  output logic [63:0] prod_o
);

  logic         run_q, done_q;
  logic [1:0]   k_q;
  logic [63:0]  a_q, b_q;
  logic [127:0] acc_q;
  logic [63:0]  pp;
  logic [1:0]   sh;

  // one 32x32 partial product per cycle
  always_comb begin
    pp = (k_q[0] ? a_q[63:32] : a_q[31:0]) * (k_q[1] ? b_q[63:32] : b_q[31:0]);
    sh = 2'(k_q[0]) + 2'(k_q[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      k_q    <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        k_q   <= 2'd0;
      end else if (run_q) begin
        k_q <= k_q + 2'd1;
        if (k_q == 2'd3) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= 128'd0;
    end else if (run_q) begin
      acc_q <= acc_q + (128'(pp) << {sh, 5'b00000});
    end
  end

  // Q32.32 product, saturated on overflow
  assign done_o = done_q;
  assign prod_o = (|acc_q[127:96]) ? {64{1'b1}} : acc_q[95:32];

endmodule
`default_nettype wire

FILE: rtl/lsq4_solver.sv
`default_nettype none
module lsq4_solver #(
  parameter int COUNT_BITS = lsq4_pkg::COUNT_BITS_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire  [31:0]          pivot_floor_i,
  input  wire                  q_valid_i,
  input  lsq4_pkg::sums_t      sums_i,
  input  wire  [COUNT_BITS:0]  count_i,
  output logic                 pop_o,
  output logic                 result_valid_o,
  output logic [1:0]           status_o,
  output logic [31:0]          intercept_o,
  output logic [31:0]          surface_gain_o,
  output logic [31:0]          vegetation_gain_o,
  output logic [31:0]          height_gain_o
);

  localparam int CW = COUNT_BITS + 1;

  lsq4_pkg::solve_state_e st_q, st_d;
  lsq4_pkg::status_e      status_q;

  logic [63:0] w_q [20];
  logic [63:0] beta_q [4];
  logic [1:0]  perm_q [4];
  logic [1:0]  p_q, i_q, li_q, best_i_q, best_row_q, prow_q;
  logic [2:0]  j_q, lj_q;
  logic [63:0] best_q, diag_q, f_q, acc_q;
  logic        neg_q;

  // datapath control
  logic        div_start, mul_start, div_done, mul_done;
  logic [63:0] div_hi, div_lo, div_den, div_quo, mul_a, mul_b, mul_m;
  logic [1:0]  rd_log, rd_phys;
  logic [2:0]  rd_col;
  logic [63:0] rdata, rmag, sum_v, sum_m, term, acc_new;
  logic [3:0]  sum_idx;
  logic        few, singular, last_load;

  assign few       = (count_i < CW'(4));
  assign singular  = (best_q == 64'd0) || (best_q < {32'd0, pivot_floor_i});
  assign last_load = (li_q == 2'd3) && (lj_q == lsq4_pkg::LAST_COL);

  // single read port of the work matrix, through the row map
  always_comb begin
    rd_log = i_q;
    rd_col = j_q;
    case (st_q)
      lsq4_pkg::S_PIV, lsq4_pkg::S_ELIM_F: rd_col = {1'b0, p_q};
      lsq4_pkg::S_DIAG: begin
        rd_log = p_q;
        rd_col = {1'b0, p_q};
      end
      lsq4_pkg::S_NORM, lsq4_pkg::S_NORM_W, lsq4_pkg::S_ELIM_M: rd_log = p_q;
      lsq4_pkg::S_BACK_INIT: rd_col = lsq4_pkg::LAST_COL;
      default: ;
    endcase
    rd_phys = perm_q[rd_log];
    rdata   = w_q[lsq4_pkg::w_index(rd_phys, rd_col)];
    rmag    = lsq4_pkg::mag64(rdata);
    sum_idx = (lj_q == lsq4_pkg::LAST_COL) ? (4'd10 + 4'(li_q))
                                           : lsq4_pkg::SUM_SEL[{li_q, lj_q[1:0]}];
    sum_v   = sums_i[sum_idx];
    sum_m   = lsq4_pkg::mag64(sum_v);
    term    = lsq4_pkg::from_mag(mul_m, neg_q);
    acc_new = lsq4_pkg::add_sat((st_q == lsq4_pkg::S_BACK_MW) ? acc_q : rdata,
                                64'd0 - term);
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      lsq4_pkg::S_IDLE: begin
        if (q_valid_i) st_d = few ? lsq4_pkg::S_OUT : lsq4_pkg::S_LOAD;
      end
      lsq4_pkg::S_LOAD: st_d = lsq4_pkg::S_LOAD_W;
      lsq4_pkg::S_LOAD_W: begin
        if (div_done) st_d = last_load ? lsq4_pkg::S_PIV : lsq4_pkg::S_LOAD;
      end
      lsq4_pkg::S_PIV: if (i_q == 2'd3) st_d = lsq4_pkg::S_PIV_CHK;
      lsq4_pkg::S_PIV_CHK: st_d = singular ? lsq4_pkg::S_OUT : lsq4_pkg::S_DIAG;
      lsq4_pkg::S_DIAG: st_d = lsq4_pkg::S_NORM;
      lsq4_pkg::S_NORM: st_d = lsq4_pkg::S_NORM_W;
      lsq4_pkg::S_NORM_W: begin
        if (div_done) begin
          if (j_q != lsq4_pkg::LAST_COL) st_d = lsq4_pkg::S_NORM;
          else if (p_q == 2'd3) st_d = lsq4_pkg::S_BACK_INIT;
          else st_d = lsq4_pkg::S_ELIM_F;
        end
      end
      lsq4_pkg::S_ELIM_F: st_d = lsq4_pkg::S_ELIM_M;
      lsq4_pkg::S_ELIM_M: st_d = lsq4_pkg::S_ELIM_MW;
      lsq4_pkg::S_ELIM_MW: begin
        if (mul_done) begin
          if (j_q != lsq4_pkg::LAST_COL) st_d = lsq4_pkg::S_ELIM_M;
          else if (i_q == 2'd3) st_d = lsq4_pkg::S_PIV;
          else st_d = lsq4_pkg::S_ELIM_F;
        end
      end
      lsq4_pkg::S_BACK_INIT: st_d = (i_q == 2'd3) ? lsq4_pkg::S_BACK_INIT : lsq4_pkg::S_BACK_M;
      lsq4_pkg::S_BACK_M: st_d = lsq4_pkg::S_BACK_MW;
      lsq4_pkg::S_BACK_MW: begin
        if (mul_done) begin
          if (j_q != 3'd3) st_d = lsq4_pkg::S_BACK_M;
          else if (i_q == 2'd0) st_d = lsq4_pkg::S_OUT;
          else st_d = lsq4_pkg::S_BACK_INIT;
        end
      end
      lsq4_pkg::S_OUT: st_d = lsq4_pkg::S_IDLE;
      default: st_d = lsq4_pkg::S_IDLE;
    endcase
  end

  // unit strobes and operands
  always_comb begin
    div_start = 1'b0;
    mul_start = 1'b0;
    pop_o     = 1'b0;
    div_hi    = rmag >> 32;
    div_lo    = rmag << 32;
    div_den   = lsq4_pkg::mag64(diag_q);
    mul_a     = lsq4_pkg::mag64(f_q);
    mul_b     = rmag;
    case (st_q)
      lsq4_pkg::S_IDLE: pop_o = q_valid_i && few;
      lsq4_pkg::S_LOAD: begin
        div_start = 1'b1;
        div_hi    = sum_m >> 48;
        div_lo    = sum_m << 16;
        div_den   = 64'(count_i);
      end
      lsq4_pkg::S_LOAD_W: pop_o = div_done && last_load;
      lsq4_pkg::S_NORM: div_start = 1'b1;
      lsq4_pkg::S_ELIM_M: mul_start = 1'b1;
      lsq4_pkg::S_BACK_M: begin
        mul_start = 1'b1;
        mul_a     = rmag;
        mul_b     = lsq4_pkg::mag64(beta_q[j_q[1:0]]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= lsq4_pkg::S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk_i) begin
    case (st_q)
      lsq4_pkg::S_IDLE: begin
        li_q     <= 2'd0;
        lj_q     <= 3'd0;
        status_q <= few ? lsq4_pkg::ST_FEW : lsq4_pkg::ST_OK;
        for (int k = 0; k < 4; k++) beta_q[k] <= 64'd0;
      end
      lsq4_pkg::S_LOAD: neg_q <= sum_v[63];
      lsq4_pkg::S_LOAD_W: begin
        if (div_done) begin
          w_q[lsq4_pkg::w_index(li_q, lj_q)] <= lsq4_pkg::from_mag(div_quo, neg_q);
          if (lj_q == lsq4_pkg::LAST_COL) begin
            lj_q <= 3'd0;
            li_q <= li_q + 2'd1;
          end else begin
            lj_q <= lj_q + 3'd1;
          end
          for (int k = 0; k < 4; k++) perm_q[k] <= 2'(k);
          p_q <= 2'd0;
          i_q <= 2'd0;
        end
      end
      lsq4_pkg::S_PIV: begin
        if (i_q == p_q) begin
          best_q     <= rmag;
          best_i_q   <= i_q;
          best_row_q <= rd_phys;
          prow_q     <= rd_phys;
        end else if (rmag > best_q) begin
          best_q     <= rmag;
          best_i_q   <= i_q;
          best_row_q <= rd_phys;
        end
        i_q <= i_q + 2'd1;
      end
      lsq4_pkg::S_PIV_CHK: begin
        if (singular) begin
          status_q <= lsq4_pkg::ST_SINGULAR;
        end else if (best_i_q != p_q) begin
          perm_q[best_i_q] <= prow_q;
          perm_q[p_q]      <= best_row_q;
        end
      end
      lsq4_pkg::S_DIAG: begin
        diag_q <= rdata;
        j_q    <= {1'b0, p_q};
      end
      lsq4_pkg::S_NORM: neg_q <= rdata[63] ^ diag_q[63];
      lsq4_pkg::S_NORM_W: begin
        if (div_done) begin
          w_q[lsq4_pkg::w_index(rd_phys, rd_col)] <= lsq4_pkg::from_mag(div_quo, neg_q);
          j_q <= j_q + 3'd1;
          i_q <= (p_q == 2'd3) ? 2'd3 : (p_q + 2'd1);
        end
      end
      lsq4_pkg::S_ELIM_F: begin
        f_q <= rdata;
        j_q <= {1'b0, p_q};
      end
      lsq4_pkg::S_ELIM_M: neg_q <= f_q[63] ^ rdata[63];
      lsq4_pkg::S_ELIM_MW: begin
        if (mul_done) begin
          w_q[lsq4_pkg::w_index(rd_phys, rd_col)] <= acc_new;
          j_q <= j_q + 3'd1;
          if (j_q == lsq4_pkg::LAST_COL) begin
            if (i_q == 2'd3) begin
              p_q <= p_q + 2'd1;
              i_q <= p_q + 2'd1;
            end else begin
              i_q <= i_q + 2'd1;
            end
          end
        end
      end
      lsq4_pkg::S_BACK_INIT: begin
        if (i_q == 2'd3) begin
          beta_q[3] <= rdata;
          i_q       <= 2'd2;
        end else begin
          acc_q <= rdata;
          j_q   <= 3'(i_q) + 3'd1;
        end
      end
      lsq4_pkg::S_BACK_M: neg_q <= rdata[63] ^ beta_q[j_q[1:0]][63];
      lsq4_pkg::S_BACK_MW: begin
        if (mul_done) begin
          acc_q <= acc_new;
          j_q   <= j_q + 3'd1;
          if (j_q == 3'd3) begin
            beta_q[i_q] <= acc_new;
            i_q         <= i_q - 2'd1;
          end
        end
      end
      default: ;
    endcase
  end

  lsq4_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .hi_i    (div_hi),
    .lo_i    (div_lo),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  lsq4_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_m)
  );

  // result, shown for the one cycle of S_OUT
  always_comb begin
    result_valid_o    = (st_q == lsq4_pkg::S_OUT);
    status_o          = status_q;
    intercept_o       = lsq4_pkg::to_q16(beta_q[3]);
    surface_gain_o    = lsq4_pkg::to_q16(beta_q[0]);
    vegetation_gain_o = lsq4_pkg::to_q16(beta_q[1]);
    height_gain_o     = lsq4_pkg::to_q16(beta_q[2]);
  end

endmodule
`default_nettype wire

FILE: rtl/least_squares_four_term_fit.sv
// Channel   Direction  Handshake                    Payload
// sample    in         start & !busy                surface_temp_i .. last_sample_i
// result    out        result_valid_o (1 cycle)     status_o, four Q16.16 coefficients
// config    in         pivot_floor_we_i             pivot_floor_i
//
// A request is taken while idle, then four 16x16 lane multipliers update the
// fourteen sums in four phases; a new sample is taken only after that. A last sample
// adds a push state to hand the sums to a one-entry queue; busy holds while it is full.
// A solve is spent mostly in the 64-step serial divider (34 divisions).
// Reset clears the sums, the count and the queue, and sets pivot_floor to 1.
// Results cannot be stalled by the receiver.
`default_nettype none
module least_squares_four_term_fit #(
  parameter int COUNT_BITS = lsq4_pkg::COUNT_BITS_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output logic               busy,
  input  wire  signed [15:0] surface_temp_i,
  input  wire  signed [15:0] vegetation_index_i,
  input  wire  signed [15:0] building_height_i,
  input  wire  signed [15:0] air_temp_observed_i,
  input  wire                last_sample_i,
  input  wire                pivot_floor_we_i,
  input  wire  [31:0]        pivot_floor_i,
  output logic               result_valid_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] intercept_o,
  output logic signed [31:0] surface_gain_o,
  output logic signed [31:0] vegetation_gain_o,
  output logic signed [31:0] height_gain_o
);

  logic [31:0]          floor_q;
  logic                 push, full, q_valid, pop;
  lsq4_pkg::sums_t      f_sums, q_sums;
  logic [COUNT_BITS:0]  f_count, q_count;
  logic [31:0]          icpt, sgain, vgain, hgain;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= lsq4_pkg::PIVOT_FLOOR_RST;
    end else if (pivot_floor_we_i) begin
      floor_q <= pivot_floor_i;
    end
  end

  lsq4_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .surface_temp_i      (surface_temp_i),
    .vegetation_index_i  (vegetation_index_i),
    .building_height_i   (building_height_i),
    .air_temp_observed_i (air_temp_observed_i),
    .last_sample_i       (last_sample_i),
    .q_full_i            (full),
    .push_o              (push),
    .sums_o              (f_sums),
    .count_o             (f_count)
  );

  lsq4_queue #(.COUNT_BITS(COUNT_BITS)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .sums_i  (f_sums),
    .count_i (f_count),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .sums_o  (q_sums),
    .count_o (q_count)
  );

  lsq4_solver #(.COUNT_BITS(COUNT_BITS)) u_solver (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .pivot_floor_i     (floor_q),
    .q_valid_i         (q_valid),
    .sums_i            (q_sums),
    .count_i           (q_count),
    .pop_o             (pop),
    .result_valid_o    (result_valid_o),
    .status_o          (status_o),
    .intercept_o       (icpt),
    .surface_gain_o    (sgain),
    .vegetation_gain_o (vgain),
    .height_gain_o     (hgain)
  );

  assign intercept_o       = $signed(icpt);
  assign surface_gain_o    = $signed(sgain);
  assign vegetation_gain_o = $signed(vgain);
  assign height_gain_o     = $signed(hgain);

endmodule
`default_nettype wire

FILE: sim/least_squares_four_term_fit_checker.sv
`timescale 1ns / 1ps
module least_squares_four_term_fit_checker (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  input  wire                busy,
  input  wire  signed [15:0] surface_temp_i,
  input  wire  signed [15:0] vegetation_index_i,
  input  wire  signed [15:0] building_height_i,
  input  wire  signed [15:0] air_temp_observed_i,
  input  wire                last_sample_i,
  input  wire                pivot_floor_we_i,
  input  wire  [31:0]        pivot_floor_i,
  input  wire                result_valid_o,
  input  wire  [1:0]         status_o,
  input  wire  [31:0]        intercept_o,
  input  wire  [31:0]        surface_gain_o,
  input  wire  [31:0]        vegetation_gain_o,
  input  wire  [31:0]        height_gain_o,
  output int                 mismatches_o,
  output int                 pending_o
);

  localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [16:0] COUNT_TOP = 17'h1FFFF;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] intercept;
    logic [31:0] surface;
    logic [31:0] vegetation;
    logic [31:0] height;
  } fit_t;

  fit_t        expected_fits[$];
  logic [63:0] moment_sums[14];
  logic [16:0] sample_total;
  logic [31:0] pivot_floor_q;
  int          mismatch_count;

  function automatic logic [63:0] magv(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] signed_sat(input logic [63:0] m, input logic neg);
    logic [63:0] c;
    c = (m > Q_MAX) ? Q_MAX : m;
    return neg ? (64'd0 - c) : c;
  endfunction

  // Q32.32 product, truncated toward zero
  function automatic logic [63:0] mul_fx(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = (128'(magv(a)) * 128'(magv(b))) >> 32;
    return signed_sat((p[127:64] != 0) ? '1 : p[63:0], a[63] ^ b[63]);
  endfunction

  // Q32.32 quotient, truncated toward zero
  function automatic logic [63:0] div_fx(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] q;
    q = (128'(magv(a)) << 32) / 128'(magv(b));
    return signed_sat((q[127:64] != 0) ? '1 : q[63:0], a[63] ^ b[63]);
  endfunction

  // sum -> mean in Q32.32
  function automatic logic [63:0] mean_fx(input logic [63:0] s, input logic [16:0] n);
    logic [127:0] q;
    q = (128'(magv(s)) << 16) / 128'(n);
    return signed_sat((q[127:64] != 0) ? '1 : q[63:0], s[63]);
  endfunction

  function automatic logic [63:0] add_fx(input logic [63:0] a, input logic [63:0] b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s > $signed({1'b0, Q_MAX})) return Q_MAX;
    if (s < -$signed({1'b0, Q_MAX})) return 64'd0 - Q_MAX;
    return s[63:0];
  endfunction

  // Q32.32 -> Q16.16, nearest with ties away from zero
  function automatic logic [31:0] round_q16(input logic [63:0] v);
    logic [63:0] r;
    r = (magv(v) + 64'h8000) >> 16;
    if (v[63]) begin
      if (r > 64'h8000_0000) r = 64'h8000_0000;
      r = 64'd0 - r;
      return r[31:0];
    end
    return (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
  endfunction

  // slot of the upper-triangle moment (i,j)
  function automatic int moment_slot(input int i, input int j);
    int a, b;
    a = (i < j) ? i : j;
    b = (i < j) ? j : i;
    return a * 4 - a * (a - 1) / 2 + (b - a);
  endfunction

  task automatic solve_fit(output lsq4_pkg::status_e st, output logic [63:0] beta[4]);
    logic [63:0] w[4][5];
    logic [63:0] bm, diag, f, t, acc;
    int best;
    for (int i = 0; i < 4; i++) beta[i] = '0;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 5; j++)
        w[i][j] = mean_fx((j < 4) ? moment_sums[moment_slot(i, j)] : moment_sums[10 + i],
                          sample_total);
    // elimination with partial pivoting, first largest row wins ties
    for (int p = 0; p < 4; p++) begin
      best = p;
      bm = magv(w[p][p]);
      for (int i = p + 1; i < 4; i++) begin
        if (magv(w[i][p]) > bm) begin
          bm = magv(w[i][p]);
          best = i;
        end
      end
      if (bm == 0 || bm < {32'd0, pivot_floor_q}) begin
        st = lsq4_pkg::ST_SINGULAR;
        return;
      end
      for (int j = 0; j < 5; j++) begin
        t = w[p][j];
        w[p][j] = w[best][j];
        w[best][j] = t;
      end
      diag = w[p][p];
      for (int j = p; j < 5; j++) w[p][j] = div_fx(w[p][j], diag);
      for (int i = p + 1; i < 4; i++) begin
        f = w[i][p];
        for (int j = p; j < 5; j++) w[i][j] = add_fx(w[i][j], 64'd0 - mul_fx(f, w[p][j]));
      end
    end
    // back substitution
    for (int i = 3; i >= 0; i--) begin
      acc = w[i][4];
      for (int j = i + 1; j < 4; j++) acc = add_fx(acc, 64'd0 - mul_fx(w[i][j], beta[j]));
      beta[i] = acc;
    end
    st = lsq4_pkg::ST_OK;
  endtask

  task automatic take_sample();
    logic signed [31:0] x[4];
    logic signed [31:0] y, p;
    logic [63:0] beta[4];
    lsq4_pkg::status_e st;
    fit_t fit;
    x[0] = surface_temp_i;
    x[1] = vegetation_index_i;
    x[2] = building_height_i;
    x[3] = 32'sd256;
    y = air_temp_observed_i;
    for (int i = 0; i < 4; i++) begin
      for (int j = i; j < 4; j++) begin
        p = x[i] * x[j];
        moment_sums[moment_slot(i, j)] += {{32{p[31]}}, p};
      end
      p = x[i] * y;
      moment_sums[10 + i] += {{32{p[31]}}, p};
    end
    if (sample_total != COUNT_TOP) sample_total++;
    if (!last_sample_i) return;
    for (int i = 0; i < 4; i++) beta[i] = '0;
    if (sample_total < 4) st = lsq4_pkg::ST_FEW;
    else solve_fit(st, beta);
    if (st != lsq4_pkg::ST_OK) for (int i = 0; i < 4; i++) beta[i] = '0;
    fit.status     = st;
    fit.intercept  = round_q16(beta[3]);
    fit.surface    = round_q16(beta[0]);
    fit.vegetation = round_q16(beta[1]);
    fit.height     = round_q16(beta[2]);
    expected_fits.push_back(fit);
    for (int i = 0; i < 14; i++) moment_sums[i] = '0;
    sample_total = '0;
  endtask

  task automatic check_fit();
    fit_t want, got;
    got = {status_o, intercept_o, surface_gain_o, vegetation_gain_o, height_gain_o};
    if (expected_fits.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: unexpected fit status=%0d", $realtime, status_o);
      return;
    end
    want = expected_fits.pop_front();
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: fit mismatch exp st=%0d b=%h %h %h %h got st=%0d b=%h %h %h %h",
                 $realtime, want.status, want.intercept, want.surface, want.vegetation,
                 want.height, got.status, got.intercept, got.surface, got.vegetation,
                 got.height);
    end
  endtask

  // sample both channels and the register port at every edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 14; i++) moment_sums[i] = '0;
      sample_total = '0;
      pivot_floor_q = 32'd1;
      mismatch_count = 0;
      expected_fits.delete();
      mismatches_o <= 0;
      pending_o <= 0;
    end else begin
      if (pivot_floor_we_i) pivot_floor_q = pivot_floor_i;
      if (start && !busy) take_sample();
      if (result_valid_o) check_fit();
      mismatches_o <= mismatch_count;
      pending_o <= expected_fits.size();
    end
  end

endmodule

FILE: sim/least_squares_four_term_fit_test.sv
`timescale 1ns / 1ps
module least_squares_four_term_fit_test;

  localparam int IDLE_LIMIT = 20000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] surface_temp_i = '0;
  logic signed [15:0] vegetation_index_i = '0;
  logic signed [15:0] building_height_i = '0;
  logic signed [15:0] air_temp_observed_i = '0;
  logic               last_sample_i = 1'b0;
  logic               pivot_floor_we_i = 1'b0;
  logic [31:0]        pivot_floor_i = '0;
  logic               result_valid_o;
  logic [1:0]         status_o;
  logic signed [31:0] intercept_o;
  logic signed [31:0] surface_gain_o;
  logic signed [31:0] vegetation_gain_o;
  logic signed [31:0] height_gain_o;
  int                 mismatches;
  int                 pending_fits;
  int                 idle_cycles = 0;
  int                 burst_left = 0;

  always #6 clk_i = ~clk_i;

  least_squares_four_term_fit i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .surface_temp_i      (surface_temp_i),
    .vegetation_index_i  (vegetation_index_i),
    .building_height_i   (building_height_i),
    .air_temp_observed_i (air_temp_observed_i),
    .last_sample_i       (last_sample_i),
    .pivot_floor_we_i    (pivot_floor_we_i),
    .pivot_floor_i       (pivot_floor_i),
    .result_valid_o      (result_valid_o),
    .status_o            (status_o),
    .intercept_o         (intercept_o),
    .surface_gain_o      (surface_gain_o),
    .vegetation_gain_o   (vegetation_gain_o),
    .height_gain_o       (height_gain_o)
  );

  least_squares_four_term_fit_checker i_check (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .surface_temp_i      (surface_temp_i),
    .vegetation_index_i  (vegetation_index_i),
    .building_height_i   (building_height_i),
    .air_temp_observed_i (air_temp_observed_i),
    .last_sample_i       (last_sample_i),
    .pivot_floor_we_i    (pivot_floor_we_i),
    .pivot_floor_i       (pivot_floor_i),
    .result_valid_o      (result_valid_o),
    .status_o            (status_o),
    .intercept_o         (intercept_o),
    .surface_gain_o      (surface_gain_o),
    .vegetation_gain_o   (vegetation_gain_o),
    .height_gain_o       (height_gain_o),
    .mismatches_o        (mismatches),
    .pending_o           (pending_fits)
  );

  // watchdog: cycles with neither a request nor a result accepted
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int clip16(input int v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  // start stays high; the caller lowers it only before a gap
  task automatic send_sample(input int s, input int v, input int h, input int y,
                             input bit last);
    start <= 1'b1;
    surface_temp_i <= 16'(s);
    vegetation_index_i <= 16'(v);
    building_height_i <= 16'(h);
    air_temp_observed_i <= 16'(y);
    last_sample_i <= last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // bursts of random length, random gaps, some without any gap
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 24);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // drain all fits, let the block settle, then write the floor
  task automatic set_floor(input logic [31:0] value);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_fits != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    pivot_floor_we_i <= 1'b1;
    pivot_floor_i <= value;
    @(posedge clk_i);
    pivot_floor_we_i <= 1'b0;
  endtask

  // random sets: mostly noisy linear data, some raw noise, collinear or short sets
  task automatic run_sets(input int n_items);
    int sent, size, kind, span, a0, a1, a2, a3, xs, xv, xh, yy;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind == 9) size = $urandom_range(1, 3);
      else if ($urandom_range(0, 7) == 0) size = $urandom_range(4, 40);
      else size = $urandom_range(4, 10);
      span = 1 << $urandom_range(2, 14);
      a0 = int'($urandom_range(0, 1023)) - 512;
      a1 = int'($urandom_range(0, 1023)) - 512;
      a2 = int'($urandom_range(0, 1023)) - 512;
      a3 = int'($urandom_range(0, 65535)) - 32768;
      for (int k = 0; k < size; k++) begin
        xs = int'($urandom_range(0, 2 * span - 1)) - span;
        xv = int'($urandom_range(0, 2 * span - 1)) - span;
        xh = int'($urandom_range(0, 2 * span - 1)) - span;
        if (kind == 8) xh = xs;
        yy = a3 + (a0 * xs + a1 * xv + a2 * xh) / 256 + int'($urandom_range(0, 30)) - 15;
        if (kind == 6 || kind == 7) begin
          xs = int'($urandom_range(0, 65535)) - 32768;
          xv = int'($urandom_range(0, 65535)) - 32768;
          xh = int'($urandom_range(0, 65535)) - 32768;
          yy = int'($urandom_range(0, 65535)) - 32768;
        end
        send_sample(xs, xv, xh, clip16(yy), k == size - 1);
        sent++;
        pace();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_floor(32'd1);

    // one sample and three samples: too few
    send_sample(32767, -32768, 32767, -32768, 1'b1);
    send_sample(-32768, 32767, -32768, 32767, 1'b0);
    send_sample(1, -1, 0, 256, 1'b0);
    send_sample(0, 0, 0, 0, 1'b1);
    // four samples at the field extremes
    send_sample(32767, -32768, 0, 32767, 1'b0);
    send_sample(-32768, 32767, 256, -32768, 1'b0);
    send_sample(0, 0, 32767, 1, 1'b0);
    send_sample(-1, -1, -32768, 0, 1'b1);
    // constant regressor: singular
    for (int k = 0; k < 5; k++)
      send_sample(512, k * 300 - 700, k * k * 40, k * 100, k == 4);
    // all zero: zero pivot
    for (int k = 0; k < 4; k++) send_sample(0, 0, 0, 0, k == 3);
    // exact linear relation
    for (int k = 0; k < 6; k++)
      send_sample(k * 256 - 600, (k % 3) * 512, k * k * 64, 1000 + k * 128, k == 5);

    run_sets(110);
    set_floor(32'd0);
    run_sets(100);
    set_floor(32'hFFFF_FFFF);
    run_sets(80);
    set_floor(32'($urandom_range(0, 65535)));
    run_sets(100);
    set_floor($urandom);
    run_sets(100);

    start <= 1'b0;
    @(posedge clk_i);
    while (pending_fits != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && pending_fits == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

FILE: files.f
rtl/lsq4_pkg.sv
rtl/lsq4_front.sv
rtl/lsq4_queue.sv
rtl/lsq4_div.sv
rtl/lsq4_mul.sv
rtl/lsq4_solver.sv
rtl/least_squares_four_term_fit.sv
sim/least_squares_four_term_fit_checker.sv
sim/least_squares_four_term_fit_test.sv
